### src/ffca_pkg.sv
// ============================================================================
// ffca_pkg: shared types and constants of the first-fit slot allocator
// Field widths, operation codes, register indexes and the control groups
// that pass between the sequencer, the scan unit and the slot cells.
// ============================================================================
package ffca_pkg;

    localparam int TAG_W      = 16;
    localparam int SIZE_W     = 11;
    localparam int START_W    = 10;
    localparam int TOTAL_W    = 32;
    localparam int ACTIVE_W   = 11;
    localparam int CHARGE_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLOTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE       = 1'b1;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 11'd1024;
    localparam logic [CHARGE_W-1:0] CHARGE_RESET = 16'd10;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic clear;
        logic step;
        logic op;
    } scan_ctrl_t;

    typedef struct packed {
        logic shift;
        logic commit;
    } cell_ctrl_t;

endpackage

### src/ffca_cell.sv
// ============================================================================
// ffca_cell: one slot of the rotating slot row
// Holds a busy bit and an owner tag, takes its neighbour's contents on each
// shift and claims itself when a granted run covers its own index.
// ============================================================================
module ffca_cell
    import ffca_pkg::*;
#(
    parameter int CNT_W    = 11,
    parameter int TAG_BITS = 16,
    parameter int INDEX    = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cell_ctrl_t          ctrl,
    input  logic                in_busy,
    input  logic [TAG_BITS-1:0] in_owner,
    input  logic [CNT_W-1:0]    commit_lo,
    input  logic [CNT_W-1:0]    commit_hi,
    input  logic [TAG_BITS-1:0] commit_tag,
    output logic                busy,
    output logic [TAG_BITS-1:0] owner
);

    localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

    logic                busy_reg;
    logic                busy_next;
    logic [TAG_BITS-1:0] owner_reg;
    logic [TAG_BITS-1:0] owner_next;
    logic                in_window;

    assign in_window = (commit_lo <= MY_INDEX) && (MY_INDEX < commit_hi);

    always_comb
    begin
        busy_next  = busy_reg;
        owner_next = owner_reg;
        if (ctrl.shift)
        begin
            busy_next  = in_busy;
            owner_next = in_owner;
        end
        else if (ctrl.commit && in_window)
        begin
            busy_next  = 1'b1;
            owner_next = commit_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        owner_reg <= owner_next;
    end

    assign busy  = busy_reg;
    assign owner = owner_reg;

endmodule

### src/ffca_scan.sv
// ============================================================================
// ffca_scan: scan unit at the head of the slot row
// Looks at one slot per cycle as the row rotates past it, tracks the current
// free run for allocation and clears the first matching run for a free.
// ============================================================================
module ffca_scan
    import ffca_pkg::*;
#(
    parameter int IDX_W    = 10,
    parameter int CNT_W    = 11,
    parameter int TAG_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  scan_ctrl_t          ctrl,
    input  logic [IDX_W-1:0]    pos,
    input  logic [CNT_W-1:0]    len,
    input  logic [SIZE_W-1:0]   size,
    input  logic [TAG_BITS-1:0] tag,
    input  logic                head_busy,
    input  logic [TAG_BITS-1:0] head_owner,
    output logic                tail_busy,
    output logic                found,
    output logic [IDX_W-1:0]    start
);

    logic [IDX_W-1:0] run_start_reg;
    logic [IDX_W-1:0] run_start_next;
    logic [CNT_W-1:0] run_len_reg;
    logic [CNT_W-1:0] run_len_next;
    logic             found_reg;
    logic             found_next;
    logic             run_closed_reg;
    logic             run_closed_next;
    logic [IDX_W-1:0] start_reg;
    logic [IDX_W-1:0] start_next;
    logic             in_range;
    logic [IDX_W-1:0] run_start_cur;
    logic [CNT_W-1:0] run_len_inc;
    logic             fits;
    logic             tag_match;

    assign in_range      = CNT_W'(pos) < len;
    assign run_start_cur = (run_len_reg == '0) ? pos : run_start_reg;
    assign run_len_inc   = run_len_reg + CNT_W'(1);
    assign fits          = 32'(run_len_inc) >= 32'(size);
    assign tag_match     = head_busy && (head_owner == tag);

    always_comb
    begin
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        found_next      = found_reg;
        run_closed_next = run_closed_reg;
        start_next      = start_reg;
        tail_busy       = head_busy;
        if (ctrl.clear)
        begin
            run_start_next  = '0;
            run_len_next    = '0;
            found_next      = 1'b0;
            run_closed_next = 1'b0;
            start_next      = '0;
        end
        else if (ctrl.step && in_range)
        begin
            if (ctrl.op == OP_ALLOC)
            begin
                if (!found_reg)
                begin
                    if (head_busy)
                    begin
                        run_len_next = '0;
                    end
                    else
                    begin
                        run_start_next = run_start_cur;
                        run_len_next   = run_len_inc;
                        if (fits)
                        begin
                            found_next = 1'b1;
                            start_next = run_start_cur;
                        end
                    end
                end
            end
            else if (!run_closed_reg)
            begin
                if (tag_match)
                begin
                    tail_busy  = 1'b0;
                    found_next = 1'b1;
                    if (!found_reg)
                    begin
                        start_next = pos;
                    end
                end
                else if (found_reg)
                begin
                    run_closed_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_start_reg  <= '0;
            run_len_reg    <= '0;
            found_reg      <= 1'b0;
            run_closed_reg <= 1'b0;
            start_reg      <= '0;
        end
        else
        begin
            run_start_reg  <= run_start_next;
            run_len_reg    <= run_len_next;
            found_reg      <= found_next;
            run_closed_reg <= run_closed_next;
            start_reg      <= start_next;
        end
    end

    assign found = found_reg;
    assign start = start_reg;

endmodule

### src/first_fit_contiguous_slot_allocator.sv
// ============================================================================
// first_fit_contiguous_slot_allocator: first-fit contiguous slot allocator
// Allocates runs of free slots to owner tags and frees them again by tag.
// ============================================================================
// Requests arrive on the input channel (in_valid, in_stall, op, tag,
// run_size); a transfer happens when in_valid is high and in_stall is low.
// Each request gives one result transfer on the output channel (out_valid,
// out_stall, success, start_slot, running_total).
// The slots sit in a row of cells that rotates by one slot per cycle past a
// single scan unit. A request scans the whole row, claims a granted run and
// updates the total in the commit step, and loads the result register in
// the result step; a new request is taken only after the block returns to
// idle once its result is loaded.
// in_stall is high while a request is in progress. A waiting result does not
// hold off the next request; only the loading of the next result waits while
// out_stall is high.
// Registers are written through cfg_valid, cfg_ready, cfg_index and cfg_data;
// the user must write them only while the block is idle, as the block does
// not enforce it. cfg_ready is always high. Reset marks every slot free,
// clears the total and loads the default active length and charge.
// ============================================================================
module first_fit_contiguous_slot_allocator
    import ffca_pkg::*;
#(
    parameter int SLOT_COUNT = 1024,
    parameter int TAG_BITS   = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [TAG_W-1:0]      tag,
    input  logic [SIZE_W-1:0]     run_size,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  success,
    output logic [START_W-1:0]    start_slot,
    output logic [TOTAL_W-1:0]    running_total,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_COMMIT = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [IDX_W-1:0]      pos_reg;
    logic [IDX_W-1:0]      pos_next;
    logic                  op_reg;
    logic [TAG_BITS-1:0]   tag_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [ACTIVE_W-1:0]   active_slots_reg;
    logic [CHARGE_W-1:0]   charge_reg;
    logic [TOTAL_W-1:0]    charge_sum_reg;
    logic [TOTAL_W-1:0]    charge_sum_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  success_reg;
    logic [START_W-1:0]    start_slot_reg;
    logic [TOTAL_W-1:0]    running_total_reg;

    logic                  in_xfer;
    logic                  out_free;
    logic                  load_result;
    logic                  scan_last;
    logic [CNT_W-1:0]      len;
    logic [TOTAL_W:0]      sum_wide;
    scan_ctrl_t            scan_ctrl;
    cell_ctrl_t            cell_ctrl;
    logic                  tail_busy;
    logic                  found;
    logic [IDX_W-1:0]      found_start;
    logic [CNT_W-1:0]      commit_lo;
    logic [CNT_W-1:0]      commit_hi;

    logic                  cell_busy  [SLOT_COUNT];
    logic [TAG_BITS-1:0]   cell_owner [SLOT_COUNT];

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_xfer     = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign load_result = (state_reg == ST_RESULT) && out_free;
    assign scan_last   = (pos_reg == IDX_W'(SLOT_COUNT - 1));
    assign cfg_ready   = 1'b1;

    always_comb
    begin
        if (32'(active_slots_reg) > SLOT_COUNT)
        begin
            len = CNT_W'(SLOT_COUNT);
        end
        else
        begin
            len = CNT_W'(active_slots_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_SCAN;
                    pos_next   = '0;
                end
            end
            ST_SCAN:
            begin
                pos_next = pos_reg + IDX_W'(1);
                if (scan_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign scan_ctrl.clear = in_xfer;
    assign scan_ctrl.step  = (state_reg == ST_SCAN);
    assign scan_ctrl.op    = op_reg;

    assign cell_ctrl.shift  = (state_reg == ST_SCAN);
    assign cell_ctrl.commit = (state_reg == ST_COMMIT) && (op_reg == OP_ALLOC) && found;

    assign commit_lo = CNT_W'(found_start);
    assign commit_hi = CNT_W'(found_start) + CNT_W'(size_reg);

    assign sum_wide = {1'b0, charge_sum_reg} + (TOTAL_W + 1)'(charge_reg);

    always_comb
    begin
        charge_sum_next = charge_sum_reg;
        if (cell_ctrl.commit)
        begin
            charge_sum_next = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pos_reg          <= '0;
            active_slots_reg <= ACTIVE_RESET;
            charge_reg       <= CHARGE_RESET;
            charge_sum_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            charge_sum_reg <= charge_sum_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ACTIVE_SLOTS)
                begin
                    active_slots_reg <= cfg_data[ACTIVE_W-1:0];
                end
                else if (cfg_index == CFG_CHARGE)
                begin
                    charge_reg <= cfg_data[CHARGE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg   <= op;
            tag_reg  <= TAG_BITS'(tag);
            size_reg <= run_size;
        end
        if (load_result)
        begin
            success_reg       <= found;
            start_slot_reg    <= found ? START_W'(found_start) : '0;
            running_total_reg <= charge_sum_reg;
        end
    end

    ffca_scan #(
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W),
        .TAG_BITS (TAG_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (scan_ctrl),
        .pos        (pos_reg),
        .len        (len),
        .size       (size_reg),
        .tag        (tag_reg),
        .head_busy  (cell_busy[0]),
        .head_owner (cell_owner[0]),
        .tail_busy  (tail_busy),
        .found      (found),
        .start      (found_start)
    );

    for (genvar k = 0; k < SLOT_COUNT; k++)
    begin : g_cell
        logic                nb_busy;
        logic [TAG_BITS-1:0] nb_owner;

        if (k == SLOT_COUNT - 1)
        begin : g_tail
            assign nb_busy  = tail_busy;
            assign nb_owner = cell_owner[0];
        end
        else
        begin : g_mid
            assign nb_busy  = cell_busy[k + 1];
            assign nb_owner = cell_owner[k + 1];
        end

        ffca_cell #(
            .CNT_W    (CNT_W),
            .TAG_BITS (TAG_BITS),
            .INDEX    (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .in_busy    (nb_busy),
            .in_owner   (nb_owner),
            .commit_lo  (commit_lo),
            .commit_hi  (commit_hi),
            .commit_tag (tag_reg),
            .busy       (cell_busy[k]),
            .owner      (cell_owner[k])
        );
    end

    assign out_valid     = out_valid_reg;
    assign success       = success_reg;
    assign start_slot    = start_slot_reg;
    assign running_total = running_total_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_SCAN) && (pos_reg == '0))
        else $error("Accepted request did not start a scan at slot zero.");

    a_commit_then_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |=> (state_reg == ST_RESULT))
        else $error("Commit step was not followed by the result step.");

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (charge_sum_reg >= $past(charge_sum_reg)))
        else $error("Running total decreased.");

    a_free_no_charge: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_COMMIT) && (op_reg == OP_FREE)) |=> $stable(charge_sum_reg))
        else $error("A free request changed the running total.");

    a_fail_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !success_reg) |-> (start_slot_reg == '0))
        else $error("Failed result carries a non-zero start slot.");
`endif

endmodule

### bench/slot_allocator_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// slot_allocator_checker: result checker for the first-fit slot allocator
// Watches the request, result and register channels, keeps its own copy of
// the slot store, the active length, the charge and the running total, and
// compares every result transfer with the oldest outcome still due.
// ============================================================================
module slot_allocator_checker
    import ffca_pkg::*;
#(
    parameter int SLOT_COUNT = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  op,
    input  logic [TAG_W-1:0]      tag,
    input  logic [SIZE_W-1:0]     run_size,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  success,
    input  logic [START_W-1:0]    start_slot,
    input  logic [TOTAL_W-1:0]    running_total,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fault_count,
    output int                    outstanding
);

    typedef struct packed {
        logic                granted;
        logic [START_W-1:0]  first_slot;
        logic [TOTAL_W-1:0]  total;
    } outcome_t;

    logic [TAG_W-1:0]    owner_of [SLOT_COUNT];
    logic                occupied [SLOT_COUNT];
    logic [TOTAL_W-1:0]  charge_total;
    logic [ACTIVE_W-1:0] active_len;
    logic [CHARGE_W-1:0] grant_charge;
    outcome_t            outcomes_due [$];
    outcome_t            want;
    int                  faults;

    task automatic apply_request(input logic req_op, input logic [TAG_W-1:0] req_tag,
                                 input logic [SIZE_W-1:0] req_size, output outcome_t res);
        int           len;
        int           size;
        int           run;
        int           first;
        logic         found;
        logic [TOTAL_W:0] sum;
        len   = (active_len > SLOT_COUNT) ? SLOT_COUNT : int'(active_len);
        size  = int'(req_size);
        run   = 0;
        first = 0;
        found = 1'b0;
        if (req_op == OP_ALLOC)
        begin
            for (int i = 0; i < len && !found; i++)
            begin
                run = occupied[i] ? 0 : run + 1;
                if (size == 0 && !occupied[i])
                begin
                    found = 1'b1;
                    first = i;
                end
                else if (size != 0 && run >= size)
                begin
                    found = 1'b1;
                    first = i - size + 1;
                end
            end
            if (found)
            begin
                for (int j = first; j < first + size; j++)
                begin
                    occupied[j] = 1'b1;
                    owner_of[j] = req_tag;
                end
                sum = {1'b0, charge_total} + grant_charge;
                charge_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
            end
        end
        else
        begin
            for (int i = 0; i < len; i++)
            begin
                if (occupied[i] && owner_of[i] == req_tag)
                begin
                    if (!found)
                        first = i;
                    found       = 1'b1;
                    occupied[i] = 1'b0;
                end
                else if (found)
                    break;
            end
        end
        res.granted    = found;
        res.first_slot = found ? START_W'(first) : '0;
        res.total      = charge_total;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
                occupied[k] = 1'b0;
            charge_total = '0;
            active_len   = ACTIVE_RESET;
            grant_charge = CHARGE_RESET;
            outcomes_due.delete();
            faults       = 0;
            fault_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (outcomes_due.size() == 0)
                begin
                    if (faults < 10)
                        $display("%0t: result with none due: success %0b start %0d total %0d",
                                 $time, success, start_slot, running_total);
                    faults++;
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    if (success !== want.granted || start_slot !== want.first_slot
                        || running_total !== want.total)
                    begin
                        if (faults < 10)
                        begin
                            $display("%0t: expected success %0b start %0d total %0d,",
                                     $time, want.granted, want.first_slot, want.total);
                            $display("    got success %0b start %0d total %0d",
                                     success, start_slot, running_total);
                        end
                        faults++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ACTIVE_SLOTS: active_len   = cfg_data[ACTIVE_W-1:0];
                    CFG_CHARGE:       grant_charge = cfg_data[CHARGE_W-1:0];
                    default:          ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                apply_request(op, tag, run_size, want);
                outcomes_due = {outcomes_due, want};
            end
            fault_count <= faults;
            outstanding <= outcomes_due.size();
        end
    end

endmodule

### bench/first_fit_contiguous_slot_allocator_test.sv
`timescale 1ns / 1ps
// ============================================================================
// first_fit_contiguous_slot_allocator_test: top level of the allocator bench
// Drives a directed set of allocate and free requests, then random request
// streams under a range of active lengths and charges, some with the sender
// and receiver idling at random; a checker beside the block judges results.
// ============================================================================
module first_fit_contiguous_slot_allocator_test;
    import ffca_pkg::*;

    localparam int SLOTS = 1024;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  op        = OP_ALLOC;
    logic [TAG_W-1:0]      tag       = '0;
    logic [SIZE_W-1:0]     run_size  = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ACTIVE_SLOTS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_stall;
    logic                  out_valid;
    logic                  success;
    logic [START_W-1:0]    start_slot;
    logic [TOTAL_W-1:0]    running_total;
    logic                  cfg_ready;
    int                    fault_count;
    int                    outstanding;
    int                    idle_pct  = 0;
    int                    stall_pct = 0;
    logic [TAG_W-1:0]      tag_pool [8];

    first_fit_contiguous_slot_allocator #(.SLOT_COUNT(SLOTS), .TAG_BITS(16)) dut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .tag(tag), .run_size(run_size),
        .out_valid(out_valid), .out_stall(out_stall),
        .success(success), .start_slot(start_slot), .running_total(running_total),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    slot_allocator_checker #(.SLOT_COUNT(SLOTS)) ledger
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .tag(tag), .run_size(run_size),
        .out_valid(out_valid), .out_stall(out_stall),
        .success(success), .start_slot(start_slot), .running_total(running_total),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fault_count(fault_count), .outstanding(outstanding)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    task automatic send_request(input logic req_op, input logic [TAG_W-1:0] req_tag,
                                input logic [SIZE_W-1:0] req_size);
        int gap;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(0, 9) == 0)
            gap = $urandom_range(1, 1100);
        while (gap > 0 || $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            if (gap > 0)
                gap--;
        end
        in_valid <= 1'b1;
        op       <= req_op;
        tag      <= req_tag;
        run_size <= req_size;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || in_stall)
            @(posedge clk);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] active,
                                 input logic [CFG_DATA_W-1:0] charge);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ACTIVE_SLOTS;
        cfg_data  <= active;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_CHARGE;
        cfg_data  <= charge;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int                  span;
        int                  pick;
        int                  size_pick;
        int                  guard;
        logic [SIZE_W-1:0]   size;
        logic [ACTIVE_W-1:0] active_plan [12];
        logic [CHARGE_W-1:0] charge_plan [12];

        active_plan = '{11'd1024, 11'd64, 11'd16, 11'd2047, 11'd1, 11'd200,
                        11'd0, 11'd1024, 11'd33, 11'd1536, 11'd512, 11'd3};
        charge_plan = '{16'd0, 16'hFFFF, 16'd0, 16'd10, 16'd1, 16'd0,
                        16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd7, 16'hFFFF};
        charge_plan[0] = CHARGE_W'($urandom_range(0, 65535));
        charge_plan[5] = CHARGE_W'($urandom_range(0, 65535));
        charge_plan[9] = CHARGE_W'($urandom_range(0, 65535));
        for (int k = 0; k < 8; k++)
            tag_pool[k] = TAG_W'($urandom_range(0, 65535));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_ALLOC, 16'hFFFF, 11'd0);
        send_request(OP_ALLOC, 16'h0000, 11'd1024);
        send_request(OP_ALLOC, 16'h0001, 11'd0);
        send_request(OP_ALLOC, 16'h0001, 11'd1);
        send_request(OP_FREE,  16'h0000, 11'h7FF);
        send_request(OP_FREE,  16'h0000, 11'd0);
        send_request(OP_ALLOC, 16'hA5A5, 11'd1025);
        send_request(OP_ALLOC, 16'h5A5A, 11'd2047);
        send_request(OP_ALLOC, 16'h0003, 11'd5);
        send_request(OP_ALLOC, 16'h0004, 11'd3);
        send_request(OP_ALLOC, 16'h0003, 11'd2);
        send_request(OP_FREE,  16'h0003, 11'd0);
        send_request(OP_ALLOC, 16'h0005, 11'd6);
        send_request(OP_ALLOC, 16'h0006, 11'd4);
        send_request(OP_FREE,  16'h0004, 11'd0);
        drain_results();
        load_settings(16'd8, 16'hFFFF);
        send_request(OP_ALLOC, 16'h0007, 11'd1);
        send_request(OP_ALLOC, 16'h0008, 11'd3);
        send_request(OP_ALLOC, 16'h0009, 11'd1);
        send_request(OP_ALLOC, 16'h0009, 11'd8);
        send_request(OP_FREE,  16'h0003, 11'd0);
        drain_results();
        load_settings(16'd0, 16'd0);
        send_request(OP_ALLOC, 16'h0009, 11'd0);
        send_request(OP_FREE,  16'h0006, 11'd0);
        drain_results();
        load_settings(16'd2000, 16'd1);
        send_request(OP_FREE,  16'h0003, 11'd0);
        send_request(OP_ALLOC, 16'h8001, 11'd1);

        for (int blk = 0; blk < 12; blk++)
        begin
            drain_results();
            load_settings(CFG_DATA_W'(active_plan[blk]), charge_plan[blk]);
            case (blk / 3)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 55; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            for (int k = 0; k < 4; k++)
                tag_pool[(blk * 4 + k) % 8] = TAG_W'($urandom_range(0, 65535));
            span = (active_plan[blk] > SLOTS) ? SLOTS : int'(active_plan[blk]);
            for (int n = 0; n < 48; n++)
            begin
                pick      = $urandom_range(0, 99);
                size_pick = $urandom_range(0, 99);
                if (size_pick < 80)
                    size = SIZE_W'($urandom_range(0, 12));
                else if (size_pick < 95)
                    size = SIZE_W'($urandom_range(0, span));
                else
                    size = SIZE_W'($urandom_range(0, 2047));
                if (pick < 58)
                    send_request(OP_ALLOC, tag_pool[$urandom_range(0, 7)], size);
                else if (pick < 93)
                    send_request(OP_FREE, tag_pool[$urandom_range(0, 7)], size);
                else
                    send_request(OP_FREE, TAG_W'($urandom_range(0, 65535)), size);
            end
        end

        in_valid <= 1'b0;
        guard = 0;
        repeat (2) @(posedge clk);
        while (outstanding != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (1100) @(posedge clk);
        if (fault_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
